// ===== sv/udpr_pkg.sv =====
// Shared types, constants and command codes of the UDP port remap table.
package udpr_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [15:0] RESET_FIRST_PORT = 16'd7000;

    localparam logic [1:0] CMD_MAP = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_TEARDOWN = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] STATUS_NEW = 2'd0;
    localparam logic [1:0] STATUS_EXISTING = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_DONE = 2'd3;

    localparam logic [4:0] REMOVED_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] peer_ip;
        logic [15:0] peer_tcp_port;
        logic [15:0] peer_udp_lo;
        logic [15:0] peer_udp_hi;
        logic [15:0] query_port;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] nat_lo;
        logic [15:0] nat_hi;
        logic [15:0] peer_port;
        logic [4:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic [31:0] peer_ip;
        logic [15:0] peer_tcp;
        logic [15:0] peer_udp_lo;
        logic [15:0] peer_udp_hi;
        logic [15:0] nat_lo;
        logic [15:0] nat_hi;
    } entry_t;

    // Access from the scan controller to the table storage.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             valid_clr;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } tbl_req_t;

    typedef struct packed {
        logic   rd_valid;
        entry_t rd_data;
    } tbl_rsp_t;

endpackage

// ===== sv/udpr_ifs.sv =====
// Request and response channel interfaces of the UDP port remap table.
interface udpr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] peer_ip;
    logic [15:0] peer_tcp_port;
    logic [15:0] peer_udp_lo;
    logic [15:0] peer_udp_hi;
    logic [15:0] query_port;

    modport source (
        output valid, cmd, peer_ip, peer_tcp_port, peer_udp_lo, peer_udp_hi,
               query_port,
        input  ready
    );
    modport sink (
        input  valid, cmd, peer_ip, peer_tcp_port, peer_udp_lo, peer_udp_hi,
               query_port,
        output ready
    );
endinterface

interface udpr_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] nat_lo;
    logic [15:0] nat_hi;
    logic [15:0] peer_port;
    logic [4:0]  removed_count;

    modport source (
        output valid, status, nat_lo, nat_hi, peer_port, removed_count,
        input  ready
    );
    modport sink (
        input  valid, status, nat_lo, nat_hi, peer_port, removed_count,
        output ready
    );
endinterface

// ===== sv/udpr_table.sv =====
// Entry storage: synchronous entry memory plus per-entry valid flip-flops.
module udpr_table
    import udpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t tbl_req,
    output tbl_rsp_t tbl_rsp
);

    entry_t                   mem [TABLE_ENTRIES];
    entry_t                   rd_data_reg;
    logic                     rd_valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_req.wr_en)
        begin
            mem[tbl_req.wr_addr] <= tbl_req.wr_data;
        end
        if (tbl_req.rd_en)
        begin
            rd_data_reg <= mem[tbl_req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (tbl_req.wr_en)
            begin
                valid_reg[tbl_req.wr_addr] <= 1'b1;
            end
            else if (tbl_req.valid_clr)
            begin
                valid_reg[tbl_req.wr_addr] <= 1'b0;
            end
            if (tbl_req.rd_en)
            begin
                rd_valid_reg <= valid_reg[tbl_req.rd_addr];
            end
        end
    end

    assign tbl_rsp.rd_valid = rd_valid_reg;
    assign tbl_rsp.rd_data  = rd_data_reg;

endmodule

// ===== sv/udpr_ctrl.sv =====
// Scan controller: walks the table one entry per cycle for each map, lookup or teardown command.
module udpr_ctrl
    import udpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        req_valid,
    input  req_t        req_data,
    output logic        req_ready,
    output logic        res_valid,
    output rsp_t        res_data,
    input  logic        res_ready,
    output tbl_req_t    tbl_req,
    input  tbl_rsp_t    tbl_rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    req_t             item_reg, item_next;
    rsp_t             result_reg, result_next;
    logic [15:0]      nat_port_reg, nat_port_next;

    logic   last;
    logic   finish;
    logic   id_match;
    entry_t rd;

    assign rd       = tbl_rsp.rd_data;
    assign last     = (idx_reg == LAST_IDX);
    assign id_match = tbl_rsp.rd_valid && (rd.peer_ip == item_reg.peer_ip)
                      && (rd.peer_tcp == item_reg.peer_tcp_port);

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res_data  = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        item_next     = item_reg;
        result_next   = result_reg;
        nat_port_next = nat_port_reg;
        finish        = 1'b0;

        tbl_req           = '0;
        tbl_req.rd_addr   = idx_reg + IDX_W'(1);
        tbl_req.wr_addr   = idx_reg;
        tbl_req.wr_data.peer_ip     = item_reg.peer_ip;
        tbl_req.wr_data.peer_tcp    = item_reg.peer_tcp_port;
        tbl_req.wr_data.peer_udp_lo = item_reg.peer_udp_lo;
        tbl_req.wr_data.peer_udp_hi = item_reg.peer_udp_hi;
        tbl_req.wr_data.nat_lo      = nat_port_reg;
        tbl_req.wr_data.nat_hi      = nat_port_reg + 16'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req_data;
                    result_next = '0;
                    idx_next    = '0;
                    if (req_data.cmd == CMD_NONE)
                    begin
                        result_next.status = STATUS_DONE;
                        state_next         = ST_DONE;
                    end
                    else
                    begin
                        result_next.status = (req_data.cmd == CMD_MAP) ? STATUS_FULL
                                                                       : STATUS_DONE;
                        tbl_req.rd_en   = 1'b1;
                        tbl_req.rd_addr = '0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // The read for the following entry goes out while this one is checked.
                tbl_req.rd_en = 1'b1;
                finish        = last;
                unique case (item_reg.cmd)
                    CMD_MAP:
                    begin
                        if (!tbl_rsp.rd_valid)
                        begin
                            tbl_req.wr_en      = 1'b1;
                            result_next.status = STATUS_NEW;
                            result_next.nat_lo = nat_port_reg;
                            result_next.nat_hi = nat_port_reg + 16'd1;
                            nat_port_next      = nat_port_reg + 16'd2;
                            finish             = 1'b1;
                        end
                        else if (id_match && (rd.peer_udp_lo == item_reg.peer_udp_lo)
                                 && (rd.peer_udp_hi == item_reg.peer_udp_hi))
                        begin
                            result_next.status = STATUS_EXISTING;
                            result_next.nat_lo = rd.nat_lo;
                            result_next.nat_hi = rd.nat_hi;
                            finish             = 1'b1;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (tbl_rsp.rd_valid)
                        begin
                            if ((item_reg.query_port == rd.nat_lo)
                                || (item_reg.query_port == rd.peer_udp_lo))
                            begin
                                result_next.peer_port = rd.peer_udp_lo;
                            end
                            else if ((item_reg.query_port == rd.nat_hi)
                                     || (item_reg.query_port == rd.peer_udp_hi))
                            begin
                                result_next.peer_port = rd.peer_udp_hi;
                                finish                = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // Teardown: stored fields of a cleared entry are never used again.
                        if (id_match)
                        begin
                            tbl_req.valid_clr = 1'b1;
                            if (result_reg.removed_count != REMOVED_MAX)
                            begin
                                result_next.removed_count = result_reg.removed_count + 5'd1;
                            end
                        end
                    end
                endcase
                if (finish)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        if (cfg_we)
        begin
            nat_port_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            nat_port_reg <= RESET_FIRST_PORT;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            nat_port_reg <= nat_port_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

endmodule

// ===== sv/udp_port_remap_table.sv =====
// Top level of the UDP port remap table: scan controller, entry storage, output register.
//
//   channel   direction  transaction
//   req       in         one command: map, reverse lookup, teardown or none
//   rsp       out        one result per command
//   cfg       in         write of the first NAT port, loaded straight into the port counter
//
// A command is accepted in the idle state and then scans one entry at a time (up to 16,
// since the entry memory delivers one entry a cycle); its result is handed over from the
// done state. A map or lookup that ends early scans fewer entries; a no-op skips the scan.
// Reset empties the table at once through the valid flip-flops; no clearing pass.
// A stalled rsp holds one finished result in the output register and the next command
// waits at its end until that register frees up.
module udp_port_remap_table
    import udpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    udpr_req_if.sink      req,
    udpr_rsp_if.source    rsp
);

    req_t     req_data;
    rsp_t     res_data;
    logic     res_valid;
    logic     res_ready;
    tbl_req_t tbl_req;
    tbl_rsp_t tbl_rsp;
    logic     out_valid_reg;
    rsp_t     out_data_reg;

    assign req_data.cmd           = req.cmd;
    assign req_data.peer_ip       = req.peer_ip;
    assign req_data.peer_tcp_port = req.peer_tcp_port;
    assign req_data.peer_udp_lo   = req.peer_udp_lo;
    assign req_data.peer_udp_hi   = req.peer_udp_hi;
    assign req_data.query_port    = req.query_port;

    udpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req.valid),
        .req_data  (req_data),
        .req_ready (req.ready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .tbl_req   (tbl_req),
        .tbl_rsp   (tbl_rsp)
    );

    udpr_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .tbl_req (tbl_req),
        .tbl_rsp (tbl_rsp)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_data_reg.status;
    assign rsp.nat_lo        = out_data_reg.nat_lo;
    assign rsp.nat_hi        = out_data_reg.nat_hi;
    assign rsp.peer_port     = out_data_reg.peer_port;
    assign rsp.removed_count = out_data_reg.removed_count;

endmodule

// ===== test/udp_port_remap_table_test.sv =====
// Self-checking testbench of the UDP port remap table: directed and random commands.
`timescale 1ns / 1ps

module udp_port_remap_table_test;
    import udpr_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int PHASE_ITEMS = 210;
    localparam int POOL_SIZE = 8;
    localparam int HOLD_AT = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_ERRORS = 10;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    udpr_req_if req ();
    udpr_rsp_if rsp ();

    udp_port_remap_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // Table model and the port allocation counter.
    logic        slot_used [TABLE_ENTRIES];
    entry_t      slot_map [TABLE_ENTRIES];
    logic [15:0] alloc_port;

    req_t pending_cmds [$];
    rsp_t expected_rsps [$];

    int   send_idle_pct = 18;
    int   recv_idle_pct = 60;
    logic req_taken = 1'b0;
    int   accepted_count = 0;
    int   stall_left = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Applies one command to the table model and returns the result it must produce.
    function automatic rsp_t remap_apply(input req_t c);
        rsp_t r;
        logic hit;
        r = '0;
        r.status = STATUS_DONE;
        hit = 1'b0;
        case (c.cmd)
            CMD_MAP:
            begin
                r.status = STATUS_FULL;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!hit && slot_used[i])
                    begin
                        if (slot_map[i].peer_ip == c.peer_ip &&
                            slot_map[i].peer_tcp == c.peer_tcp_port &&
                            slot_map[i].peer_udp_lo == c.peer_udp_lo &&
                            slot_map[i].peer_udp_hi == c.peer_udp_hi)
                        begin
                            r.status = STATUS_EXISTING;
                            r.nat_lo = slot_map[i].nat_lo;
                            r.nat_hi = slot_map[i].nat_hi;
                            hit = 1'b1;
                        end
                    end
                    else if (!hit)
                    begin
                        // The scan stops at the first free slot, even if a match lies above.
                        slot_used[i] = 1'b1;
                        slot_map[i].peer_ip = c.peer_ip;
                        slot_map[i].peer_tcp = c.peer_tcp_port;
                        slot_map[i].peer_udp_lo = c.peer_udp_lo;
                        slot_map[i].peer_udp_hi = c.peer_udp_hi;
                        slot_map[i].nat_lo = alloc_port;
                        slot_map[i].nat_hi = alloc_port + 16'd1;
                        alloc_port = alloc_port + 16'd2;
                        r.status = STATUS_NEW;
                        r.nat_lo = slot_map[i].nat_lo;
                        r.nat_hi = slot_map[i].nat_hi;
                        hit = 1'b1;
                    end
                end
            end
            CMD_LOOKUP:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (!hit && slot_used[i])
                    begin
                        // A low-port match is remembered and the scan goes on; a high one ends it.
                        if (c.query_port == slot_map[i].nat_lo ||
                            c.query_port == slot_map[i].peer_udp_lo)
                        begin
                            r.peer_port = slot_map[i].peer_udp_lo;
                        end
                        else if (c.query_port == slot_map[i].nat_hi ||
                                 c.query_port == slot_map[i].peer_udp_hi)
                        begin
                            r.peer_port = slot_map[i].peer_udp_hi;
                            hit = 1'b1;
                        end
                    end
                end
            end
            CMD_TEARDOWN:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_used[i] && slot_map[i].peer_ip == c.peer_ip &&
                        slot_map[i].peer_tcp == c.peer_tcp_port)
                    begin
                        slot_used[i] = 1'b0;
                        slot_map[i] = '0;
                        if (r.removed_count != REMOVED_MAX)
                            r.removed_count = r.removed_count + 5'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic req_t make_req(input logic [1:0] op, input logic [31:0] ip,
                                      input logic [15:0] tcp, input logic [15:0] lo,
                                      input logic [15:0] hi, input logic [15:0] q);
        req_t c;
        c.cmd = op;
        c.peer_ip = ip;
        c.peer_tcp_port = tcp;
        c.peer_udp_lo = lo;
        c.peer_udp_hi = hi;
        c.query_port = q;
        return c;
    endfunction

    // Random commands around a small pool of client sessions, so that maps hit existing
    // entries, lookups find ports and teardowns clear several entries at once.
    task automatic queue_random_phase(input int count, input logic [15:0] base);
        logic [31:0]  pool_ip [POOL_SIZE];
        logic [15:0]  pool_tcp [POOL_SIZE];
        logic [15:0]  pool_lo [POOL_SIZE][2];
        logic [15:0]  pool_hi [POOL_SIZE][2];
        logic [127:0] noise;
        req_t         c;
        int           s;
        int           k;
        int           pick;
        int           maps;
        for (int j = 0; j < POOL_SIZE; j++)
        begin
            // Some sessions share a client address; their TCP and UDP ports are drawn independently.
            pool_ip[j] = (j % 4 == 3) ? pool_ip[j - 1] : $urandom;
            pool_tcp[j] = 16'($urandom);
            for (int p = 0; p < 2; p++)
            begin
                pool_lo[j][p] = ($urandom_range(3, 0) == 0) ?
                                base + 16'($urandom_range(40, 0)) : 16'($urandom);
                pool_hi[j][p] = ($urandom_range(3, 0) == 0) ?
                                base + 16'($urandom_range(40, 0)) : 16'($urandom);
            end
        end
        maps = 0;
        repeat (count)
        begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            c = noise[$bits(req_t)-1:0];
            s = $urandom_range(POOL_SIZE - 1, 0);
            k = $urandom_range(1, 0);
            pick = $urandom_range(99, 0);
            if (pick < 55)
            begin
                c.cmd = CMD_MAP;
                if ($urandom_range(7, 0) != 0)
                begin
                    c.peer_ip = pool_ip[s];
                    c.peer_tcp_port = pool_tcp[s];
                    c.peer_udp_lo = pool_lo[s][k];
                    c.peer_udp_hi = pool_hi[s][k];
                end
                maps++;
            end
            else if (pick < 78)
            begin
                c.cmd = CMD_LOOKUP;
                case ($urandom_range(3, 0))
                    0: c.query_port = pool_lo[s][k];
                    1: c.query_port = pool_hi[s][k];
                    2: c.query_port = base + 16'($urandom_range(2 * maps + 1, 0));
                    default: ;
                endcase
            end
            else if (pick < 95)
            begin
                c.cmd = CMD_TEARDOWN;
                c.peer_ip = pool_ip[s];
                if ($urandom_range(7, 0) != 0)
                    c.peer_tcp_port = pool_tcp[s];
            end
            else
            begin
                c.cmd = CMD_NONE;
            end
            pending_cmds.push_back(c);
        end
    endtask

    // Checked at the rising edge, where the driver's outputs have settled.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || req.valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_first_port(input logic [15:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        alloc_port = value;
    endtask

    // Command driver: a new command is offered once the previous one has been taken.
    always @(negedge clk)
    begin : drive_cmds
        req_t next_cmd;
        if (rst_n && (req_taken || !req.valid))
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                req.valid <= 1'b1;
                req.cmd <= next_cmd.cmd;
                req.peer_ip <= next_cmd.peer_ip;
                req.peer_tcp_port <= next_cmd.peer_tcp_port;
                req.peer_udp_lo <= next_cmd.peer_udp_lo;
                req.peer_udp_hi <= next_cmd.peer_udp_hi;
                req.query_port <= next_cmd.query_port;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= (stall_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // One long hold-off of the result channel while commands keep coming.
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_left <= 0;
        else if (req_taken && accepted_count == HOLD_AT)
            stall_left <= HOLD_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Monitor: predicts each accepted command and checks each accepted result.
    always @(posedge clk)
    begin : watch_channels
        req_t got_cmd;
        rsp_t got;
        rsp_t want;
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= req.valid && req.ready;
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.nat_lo = rsp.nat_lo;
                got.nat_hi = rsp.nat_hi;
                got.peer_port = rsp.peer_port;
                got.removed_count = rsp.removed_count;
                if (expected_rsps.size() == 0)
                begin
                    if (mismatch_count < SHOWN_ERRORS)
                        $display("%0t: result with no command pending: status %0d nat %0d/%0d "
                                 , $time, got.status, got.nat_lo, got.nat_hi,
                                 "client %0d removed %0d", got.peer_port,
                                 got.removed_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got.status !== want.status || got.nat_lo !== want.nat_lo ||
                        got.nat_hi !== want.nat_hi || got.peer_port !== want.peer_port ||
                        got.removed_count !== want.removed_count)
                    begin
                        if (mismatch_count < SHOWN_ERRORS)
                            $display("%0t: expected status %0d nat %0d/%0d client %0d ",
                                     $time, want.status, want.nat_lo, want.nat_hi,
                                     want.peer_port, "removed %0d, got status %0d ",
                                     want.removed_count, got.status,
                                     "nat %0d/%0d client %0d removed %0d", got.nat_lo,
                                     got.nat_hi, got.peer_port, got.removed_count);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                got_cmd.cmd = req.cmd;
                got_cmd.peer_ip = req.peer_ip;
                got_cmd.peer_tcp_port = req.peer_tcp_port;
                got_cmd.peer_udp_lo = req.peer_udp_lo;
                got_cmd.peer_udp_hi = req.peer_udp_hi;
                got_cmd.query_port = req.query_port;
                expected_rsps.push_back(remap_apply(got_cmd));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin : sequence_run
        logic [15:0] last_base;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.cmd = CMD_MAP;
        req.peer_ip = '0;
        req.peer_tcp_port = '0;
        req.peer_udp_lo = '0;
        req.peer_udp_hi = '0;
        req.query_port = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_map[i] = '0;
        end
        alloc_port = RESET_FIRST_PORT;

        // Directed part, with the counter at its reset value.
        pending_cmds.push_back(make_req(CMD_LOOKUP, '0, '0, '0, '0, 16'hFFFF));
        pending_cmds.push_back(make_req(CMD_TEARDOWN, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0));
        pending_cmds.push_back(make_req(CMD_NONE, 32'hA5A5_5A5A, 16'h1234, 16'hFFFF, '0,
                                        16'h8001));
        pending_cmds.push_back(make_req(CMD_MAP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        '0));
        pending_cmds.push_back(make_req(CMD_MAP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        '0));
        pending_cmds.push_back(make_req(CMD_MAP, '0, '0, '0, '0, 16'hFFFF));
        pending_cmds.push_back(make_req(CMD_MAP, 32'hFFFF_FFFF, 16'hFFFF, 16'd5000, 16'd5001,
                                        '0));
        pending_cmds.push_back(make_req(CMD_MAP, 32'd1, 16'd1, 16'd111, 16'd222, '0));
        // Its low client port equals the translated low port of the entry before it.
        pending_cmds.push_back(make_req(CMD_MAP, 32'd2, 16'd2, 16'd7006, 16'd333, '0));
        pending_cmds.push_back(make_req(CMD_LOOKUP, '0, '0, '0, '0, 16'd7006));
        pending_cmds.push_back(make_req(CMD_LOOKUP, '0, '0, '0, '0, 16'd5001));
        pending_cmds.push_back(make_req(CMD_TEARDOWN, '0, '0, '0, '0, '0));
        // The session still sits higher up, but the freed slot below is reached first.
        pending_cmds.push_back(make_req(CMD_MAP, 32'd1, 16'd1, 16'd111, 16'd222, '0));
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(make_req(CMD_MAP, $urandom, 16'($urandom),
                                            16'($urandom), 16'($urandom), 16'($urandom)));
        pending_cmds.push_back(make_req(CMD_TEARDOWN, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        // The counter wraps on the first allocation.
        write_first_port(16'hFFFF);
        queue_random_phase(PHASE_ITEMS, 16'hFFFF);
        wait_drained();

        send_idle_pct = 60;
        recv_idle_pct = 18;
        write_first_port(16'h0000);
        queue_random_phase(PHASE_ITEMS, 16'h0000);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        last_base = 16'($urandom);
        write_first_port(last_base);
        queue_random_phase(PHASE_ITEMS, last_base);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/udpr_pkg.sv
sv/udpr_ifs.sv
sv/udpr_table.sv
sv/udpr_ctrl.sv
sv/udp_port_remap_table.sv
test/udp_port_remap_table_test.sv
